### design/sbsh_pkg.sv
package sbsh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_beat;

    // Eight hash words, index 0 is word a / H0.
    typedef logic [7:0][31:0] t_hash_words;

    // Sixteen schedule words, index 0 is the oldest and sits at the top.
    typedef logic [0:15][31:0] t_sched;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_HAND
    } t_state;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;
    localparam logic [63:0] BYTE_BITS = 64'd8;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

### design/sbsh_round.sv
module sbsh_round
    import sbsh_pkg::*;
(
    input  t_hash_words i_wv,
    input  logic [31:0] i_k,
    input  t_sched      i_win,
    output t_hash_words o_wv,
    output logic [31:0] o_w_next
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
        return (x >> n) | (x << (6'd32 - {1'b0, n}));
    endfunction

    logic [31:0] big_s0;
    logic [31:0] big_s1;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] sm_s0;
    logic [31:0] sm_s1;

    // One compression round on the current schedule word.
    always_comb begin
        big_s1 = rotr(i_wv[4], 5'd6) ^ rotr(i_wv[4], 5'd11) ^ rotr(i_wv[4], 5'd25);
        big_s0 = rotr(i_wv[0], 5'd2) ^ rotr(i_wv[0], 5'd13) ^ rotr(i_wv[0], 5'd22);
        ch     = (i_wv[4] & i_wv[5]) ^ (~i_wv[4] & i_wv[6]);
        maj    = (i_wv[0] & i_wv[1]) ^ (i_wv[0] & i_wv[2]) ^ (i_wv[1] & i_wv[2]);
        t1     = i_wv[7] + big_s1 + ch + i_k + i_win[0];
        t2     = big_s0 + maj;
        o_wv[7] = i_wv[6];
        o_wv[6] = i_wv[5];
        o_wv[5] = i_wv[4];
        o_wv[4] = i_wv[3] + t1;
        o_wv[3] = i_wv[2];
        o_wv[2] = i_wv[1];
        o_wv[1] = i_wv[0];
        o_wv[0] = t1 + t2;
    end

    // Schedule word sixteen places ahead of the one in use.
    always_comb begin
        sm_s0    = rotr(i_win[1], 5'd7) ^ rotr(i_win[1], 5'd18) ^ (i_win[1] >> 3);
        sm_s1    = rotr(i_win[14], 5'd17) ^ rotr(i_win[14], 5'd19) ^ (i_win[14] >> 10);
        o_w_next = i_win[0] + sm_s0 + i_win[9] + sm_s1;
    end

endmodule

### design/sha256_byte_stream_hasher.sv
// SHA-256 hasher fed one byte per input beat.
//
// Input channel (i_valid / o_stall): each beat carries data_byte, byte_present
// and message_end. A beat with message_end closes the message; its byte, if
// present, belongs to the message. A beat with neither flag does nothing.
// Output channel (o_valid / i_stall): eight beats per message, digest words
// 0 (most significant) to 7, last_word set on word 7.
//
// Flow: a byte beat is taken while idle. Every 64th byte starts a block: 64
// rounds in the shared round unit, one per cycle, then a fold of the result
// into the chain value; o_stall stays high through both. At message end the
// padding bytes are pushed one per cycle outside the blocks (up to 64, or up
// to 72 when the length spills into a second block), each full block again
// going through the rounds and the fold, then ST_HAND hands the digest to the
// output register. Input is held off while a block runs the round loop.
// The digest sits in its own register, so the next message is taken while
// the words drain. Should that next message finish before the previous digest
// is taken, the block holds off input until the output register is free.
// Reset (synchronous, active low) loads the initial hash values, clears the
// length and drops any pending output.
module sha256_byte_stream_hasher
    import sbsh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_in,
    input  logic      i_valid,
    output logic      o_stall,
    output t_out_beat o_out,
    output logic      o_valid,
    input  logic      i_stall
);

    t_state      r_state, n_state;
    t_hash_words r_chain, n_chain;
    t_hash_words r_wv, n_wv;
    t_hash_words r_dig, n_dig;
    t_sched      r_win, n_win;
    logic [5:0]  r_rnd, n_rnd;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic        r_pad_act, n_pad_act;
    logic        r_pad_first, n_pad_first;
    logic        r_len_ok, n_len_ok;
    logic        r_final, n_final;
    logic        r_out_busy, n_out_busy;
    logic [2:0]  r_out_idx, n_out_idx;

    logic        in_acc;
    logic        push_en;
    logic [7:0]  push_byte;
    logic        start_blk;
    logic        hand_go;
    logic        out_acc;
    logic [63:0] len_shift;
    t_hash_words rnd_wv;
    logic [31:0] w_next;

    sbsh_round u_round (
        .i_wv     (r_wv),
        .i_k      (ROUND_K[r_rnd]),
        .i_win    (r_win),
        .o_wv     (rnd_wv),
        .o_w_next (w_next)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_in.byte_present && r_fill == FILL_LAST) begin
                        n_state = ST_ROUND;
                    end else if (i_in.message_end) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                if (r_rnd == ROUND_LAST) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (r_final) begin
                    n_state = ST_HAND;
                end else if (r_pad_act) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                if (r_fill == FILL_LAST) begin
                    n_state = ST_ROUND;
                end
            end
            ST_HAND: begin
                if (!r_out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: pick the byte pushed into the block window.
    // Length bytes go out most significant first at fill positions 56..63.
    always_comb begin
        o_stall   = (r_state != ST_IDLE);
        in_acc    = 1'b0;
        push_en   = 1'b0;
        push_byte = i_in.data_byte;
        hand_go   = 1'b0;
        len_shift = r_bits >> {~r_fill[2:0], 3'b000};
        unique case (r_state)
            ST_IDLE: begin
                in_acc  = i_valid;
                push_en = i_valid && i_in.byte_present;
            end
            ST_PAD: begin
                push_en = 1'b1;
                if (r_pad_first) begin
                    push_byte = PAD_BYTE;
                end else if (r_len_ok && r_fill >= LEN_POS) begin
                    push_byte = len_shift[7:0];
                end else begin
                    push_byte = 8'h00;
                end
            end
            ST_HAND: begin
                hand_go = !r_out_busy;
            end
            default: begin
            end
        endcase
        start_blk = push_en && (r_fill == FILL_LAST);
        out_acc   = r_out_busy && !i_stall;
    end

    // Datapath next values
    always_comb begin
        n_chain     = r_chain;
        n_wv        = r_wv;
        n_dig       = r_dig;
        n_win       = r_win;
        n_rnd       = r_rnd;
        n_fill      = r_fill;
        n_bits      = r_bits;
        n_pad_act   = r_pad_act;
        n_pad_first = r_pad_first;
        n_len_ok    = r_len_ok;
        n_final     = r_final;
        n_out_busy  = r_out_busy;
        n_out_idx   = r_out_idx;

        if (push_en) begin
            n_win  = {r_win[0][23:0], r_win[1:15], push_byte};
            n_fill = r_fill + 6'd1;
        end
        if (in_acc && i_in.byte_present) begin
            n_bits = r_bits + BYTE_BITS;
        end
        if (in_acc && i_in.message_end) begin
            n_pad_act   = 1'b1;
            n_pad_first = 1'b1;
            n_len_ok    = 1'b0;
        end
        if (r_state == ST_PAD && r_pad_first) begin
            n_pad_first = 1'b0;
            n_len_ok    = (r_fill < LEN_POS);
        end
        // The block that carries the length is the last one of the message.
        if (start_blk) begin
            n_wv    = r_chain;
            n_rnd   = 6'd0;
            n_final = (r_state == ST_PAD) && r_len_ok && !r_pad_first;
        end
        if (r_state == ST_ROUND) begin
            n_wv  = rnd_wv;
            n_rnd = r_rnd + 6'd1;
            n_win = {r_win[1:15], w_next};
        end
        if (r_state == ST_FOLD) begin
            for (int i = 0; i < 8; i++) begin
                n_chain[i] = r_chain[i] + r_wv[i];
            end
            // After the spill block the length fits in the next one.
            if (r_pad_act && !r_pad_first && !r_final) begin
                n_len_ok = 1'b1;
            end
        end

        if (out_acc) begin
            n_dig     = {r_dig[7], r_dig[7:1]};
            n_out_idx = r_out_idx + 3'd1;
            if (r_out_idx == WORD_LAST) begin
                n_out_busy = 1'b0;
            end
        end
        if (hand_go) begin
            n_dig      = r_chain;
            n_out_busy = 1'b1;
            n_out_idx  = 3'd0;
            for (int i = 0; i < 8; i++) begin
                n_chain[i] = INIT_HASH[i];
            end
            n_bits    = 64'd0;
            n_pad_act = 1'b0;
            n_final   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= INIT_HASH[i];
            end
            r_rnd       <= 6'd0;
            r_fill      <= 6'd0;
            r_bits      <= 64'd0;
            r_pad_act   <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_ok    <= 1'b0;
            r_final     <= 1'b0;
            r_out_busy  <= 1'b0;
            r_out_idx   <= 3'd0;
        end else begin
            r_state     <= n_state;
            r_chain     <= n_chain;
            r_rnd       <= n_rnd;
            r_fill      <= n_fill;
            r_bits      <= n_bits;
            r_pad_act   <= n_pad_act;
            r_pad_first <= n_pad_first;
            r_len_ok    <= n_len_ok;
            r_final     <= n_final;
            r_out_busy  <= n_out_busy;
            r_out_idx   <= n_out_idx;
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        r_wv  <= n_wv;
        r_win <= n_win;
        r_dig <= n_dig;
    end

    assign o_valid           = r_out_busy;
    assign o_out.digest_word = r_dig[0];
    assign o_out.word_index  = r_out_idx;
    assign o_out.last_word   = (r_out_idx == WORD_LAST);

endmodule

### design/sbsh_checker.sv
module sbsh_checker
    import sbsh_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input t_out_beat o_out,
    input logic      o_valid,
    input logic      i_stall
);

    // Reset drops any pending digest.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Words of one digest follow each other without a gap.
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_out.last_word |=>
            o_valid && o_out.word_index == 3'($past(o_out.word_index) + 3'd1))
        else $error("digest word out of order");

    // Last flag marks word seven only.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.last_word == (o_out.word_index == WORD_LAST)))
        else $error("last_word on wrong word");

    // A digest never starts straight after the previous one ends.
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_out.last_word |=> !o_valid)
        else $error("output valid right after last word");

    // Stalled beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("stalled output beat changed");

endmodule

bind sha256_byte_stream_hasher sbsh_checker u_sbsh_checker (.*);

### sim/sha256_byte_stream_hasher_test.sv
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_test;
    import sbsh_pkg::*;

    // SHA-256 constants, kept apart from the package so that a bad table in
    // the block cannot hide behind the same bad table here.
    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam int         HOLD_CYCLES  = 700;
    localparam int         HOLD_SPACING = 224;
    localparam int         TAIL_CYCLES  = 300;
    localparam int         RANDOM_BEATS = 320;

    // receiver stall patterns, swapped at random
    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_COMB
    } t_rx_mode;

    // one queued input beat; drain_first makes the sender wait until every
    // digest word already owed has been taken before offering this beat
    typedef struct {
        t_in_beat beat;
        bit       drain_first;
    } t_pending;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    t_in_beat  i_in = '0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_out_beat o_out;
    logic      o_valid;
    logic      i_stall = 1'b0;

    sha256_byte_stream_hasher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_out   (o_out),
        .o_valid (o_valid),
        .i_stall (i_stall)
    );

    // Shadow hashing state: chain value, the partly filled 64-byte block and
    // the message length in bits.
    logic [31:0] running_hash [8];
    logic [7:0]  block_bytes [64];
    logic [63:0] length_bits;

    t_pending    pending_beats [$];
    t_out_beat   digest_due [$];

    int          beats_queued = 0;
    int          words_taken = 0;
    int          faults = 0;
    bit          in_fire = 1'b0;

    // sender burst shaping
    int          burst_left = 1;
    int          gap_left = 0;

    // receiver pattern and long hold-off
    int          hold_left = 0;
    int          next_hold_at = 16;
    int          rx_phase = 0;
    t_rx_mode    rx_mode = RX_FREE;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Fold block_bytes into running_hash: message schedule expanded in full,
    // then the 64 rounds on local working words.
    function automatic void sha_compress();
        logic [31:0] w [64];
        logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
        logic [31:0] t1, t2, s0, s1;
        for (int r = 0; r < 16; r++) begin
            w[r] = {block_bytes[4*r], block_bytes[4*r+1],
                    block_bytes[4*r+2], block_bytes[4*r+3]};
        end
        for (int r = 16; r < 64; r++) begin
            s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
            s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
            w[r] = w[r-16] + s0 + w[r-7] + s1;
        end
        va = running_hash[0];
        vb = running_hash[1];
        vc = running_hash[2];
        vd = running_hash[3];
        ve = running_hash[4];
        vf = running_hash[5];
        vg = running_hash[6];
        vh = running_hash[7];
        for (int r = 0; r < 64; r++) begin
            t1 = vh + (ror32(ve, 6) ^ ror32(ve, 11) ^ ror32(ve, 25)) +
                 ((ve & vf) ^ (~ve & vg)) + SHA_K[r] + w[r];
            t2 = (ror32(va, 2) ^ ror32(va, 13) ^ ror32(va, 22)) +
                 ((va & vb) ^ (va & vc) ^ (vb & vc));
            vh = vg;
            vg = vf;
            vf = ve;
            ve = vd + t1;
            vd = vc;
            vc = vb;
            vb = va;
            va = t1 + t2;
        end
        running_hash[0] += va;
        running_hash[1] += vb;
        running_hash[2] += vc;
        running_hash[3] += vd;
        running_hash[4] += ve;
        running_hash[5] += vf;
        running_hash[6] += vg;
        running_hash[7] += vh;
    endfunction

    // Take one accepted beat into the shadow state; on message end pad, close
    // the message and queue the eight digest words it owes.
    function automatic void absorb_beat(input t_in_beat b);
        int        pos;
        t_out_beat word;
        if (b.byte_present) begin
            pos = int'(length_bits[8:3]);
            block_bytes[pos] = b.data_byte;
            length_bits += 64'd8;
            if (pos == 63)
                sha_compress();
        end
        if (b.message_end) begin
            pos = int'(length_bits[8:3]);
            block_bytes[pos] = PAD_MARK;
            pos++;
            // long tail: no room for the length, so flush a padded block first
            if (pos > 56) begin
                while (pos < 64) begin
                    block_bytes[pos] = 8'h00;
                    pos++;
                end
                sha_compress();
                pos = 0;
            end
            while (pos < 56) begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
                block_bytes[56 + i] = length_bits[63 - 8*i -: 8];
            sha_compress();
            for (int i = 0; i < 8; i++) begin
                word.digest_word = running_hash[i];
                word.word_index  = 3'(i);
                word.last_word   = (i == 7);
                digest_due.insert(digest_due.size(), word);
            end
            running_hash = SHA_IV;
            length_bits  = '0;
        end
    endfunction

    task automatic queue_item(input logic [7:0] data, input bit present, input bit last,
                              input bit drain);
        t_pending p;
        p.beat.data_byte    = data;
        p.beat.byte_present = present;
        p.beat.message_end  = last;
        p.drain_first       = drain;
        pending_beats.insert(pending_beats.size(), p);
        if (present || last)
            beats_queued++;
    endtask

    // Queue a whole message of random bytes. Sprinkle idle beats through it,
    // and close it either on its last byte or with a separate byteless beat.
    task automatic queue_message(input int len, input bit drain);
        bit split_end;
        bit first;
        split_end = (len == 0) || ($urandom_range(0, 3) == 0);
        first = drain;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, first);
                first = 1'b0;
            end
            queue_item(8'($urandom_range(0, 255)), 1'b1, !split_end && (k == len - 1),
                       first);
            first = 1'b0;
        end
        if (split_end)
            queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, first);
    endtask

    // Sender: drive at the falling edge. Hold a stalled beat as it is; after
    // an accepted beat, either offer the next one at once or drop valid for a
    // gap. Bursts of random length, sometimes with no gap at all between them.
    always @(negedge i_clk) begin
        logic     nxt_valid;
        t_in_beat nxt_beat;
        nxt_valid = i_valid;
        nxt_beat  = i_in;
        if (in_fire) begin
            void'(pending_beats.pop_front());
            nxt_valid = 1'b0;
        end
        if (i_rst_n && !nxt_valid) begin
            if (gap_left != 0) begin
                gap_left--;
            end else if (pending_beats.size() != 0 &&
                         !(pending_beats[0].drain_first && digest_due.size() != 0)) begin
                nxt_valid = 1'b1;
                nxt_beat  = pending_beats[0].beat;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        i_valid <= nxt_valid;
        i_in    <= nxt_beat;
    end

    // Receiver: drive stall at the falling edge. Every so many digest words,
    // hold off for a long stretch so that the block fills its output register,
    // finishes the next message behind it and has to stall its input.
    always @(negedge i_clk) begin
        logic nxt_stall;
        if (hold_left != 0) begin
            hold_left--;
            nxt_stall = 1'b1;
        end else if (words_taken >= next_hold_at) begin
            hold_left    = HOLD_CYCLES;
            next_hold_at += HOLD_SPACING;
            nxt_stall    = 1'b1;
        end else begin
            rx_phase++;
            if (rx_phase % 64 == 0)
                rx_mode = t_rx_mode'($urandom_range(0, 3));
            case (rx_mode)
                RX_FREE:  nxt_stall = 1'b0;
                RX_LIGHT: nxt_stall = ($urandom_range(0, 3) == 0);
                RX_HEAVY: nxt_stall = ($urandom_range(0, 3) != 0);
                default:  nxt_stall = (rx_phase % 5 < 2);
            endcase
        end
        i_stall <= nxt_stall;
    end

    // Monitor: sample both channels at the rising edge. Feed accepted input
    // beats to the shadow hash and check each accepted output beat against
    // the oldest word still owed.
    always @(posedge i_clk) begin
        t_out_beat due;
        in_fire = i_rst_n && i_valid && !o_stall;
        if (in_fire)
            absorb_beat(i_in);
        if (i_rst_n && o_valid && !i_stall) begin
            words_taken++;
            if (digest_due.size() == 0) begin
                $display("%0t: unexpected digest beat, got word %h index %0d last %b",
                         $time, o_out.digest_word, o_out.word_index, o_out.last_word);
                faults++;
            end else begin
                due = digest_due.pop_front();
                if (o_out.digest_word !== due.digest_word) begin
                    $display("%0t: digest_word mismatch, expected %h, actual %h",
                             $time, due.digest_word, o_out.digest_word);
                    faults++;
                end
                if (o_out.word_index !== due.word_index) begin
                    $display("%0t: word_index mismatch, expected %0d, actual %0d",
                             $time, due.word_index, o_out.word_index);
                    faults++;
                end
                if (o_out.last_word !== due.last_word) begin
                    $display("%0t: last_word mismatch, expected %b, actual %b",
                             $time, due.last_word, o_out.last_word);
                    faults++;
                end
            end
        end
    end

    // Stimulus: fill the queue, release reset, then wait for the drain.
    initial begin
        running_hash = SHA_IV;
        length_bits  = '0;

        // empty message: byteless closing beat, its data byte ignored
        queue_item(8'ha5, 1'b0, 1'b1, 1'b0);
        // "abc", offered only once the empty digest has drained
        queue_item(8'h61, 1'b1, 1'b0, 1'b1);
        queue_item(8'h62, 1'b1, 1'b0, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1, 1'b0);
        // single-byte messages at the byte extremes
        queue_item(8'hff, 1'b1, 1'b1, 1'b0);
        queue_item(8'h00, 1'b1, 1'b1, 1'b0);
        // idle beats: nothing changes, nothing comes out
        queue_item(8'hff, 1'b0, 1'b0, 1'b0);
        queue_item(8'h00, 1'b0, 1'b0, 1'b0);
        // byte then a separate closing beat with a junk byte
        queue_item(8'h80, 1'b1, 1'b0, 1'b0);
        queue_item(8'hff, 1'b0, 1'b1, 1'b0);
        // idle beat in mid-message
        queue_item(8'h7f, 1'b1, 1'b0, 1'b0);
        queue_item(8'h5a, 1'b0, 1'b0, 1'b0);
        queue_item(8'h01, 1'b1, 1'b1, 1'b0);

        // tail boundaries: last fit for the length, first long tail, full block
        queue_message(55, 1'b0);
        queue_message(56, 1'b1);
        queue_message(64, 1'b0);

        // mostly short messages, a few spanning or crossing block boundaries
        while (beats_queued < RANDOM_BEATS + 13) begin
            if ($urandom_range(0, 7) == 0)
                queue_message($urandom_range(13, 70), $urandom_range(0, 5) == 0);
            else
                queue_message($urandom_range(0, 12), $urandom_range(0, 5) == 0);
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || digest_due.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (faults == 0)
            $display("sha256_byte_stream_hasher test passed");
        else
            $display("sha256_byte_stream_hasher test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("sha256_byte_stream_hasher test failed");
        $finish;
    end

endmodule
